>>> rtl/core/ffha_pkg.sv
package ffha_pkg;

	localparam int HEAP_BYTES_DEFAULT = 32768;
	localparam int HDR_LEN = 5;
	localparam int SUM_W = 33;
	localparam int SIZE_W = 32;

	localparam logic [7:0] USED_BIT = 8'h01;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE = 1'b1;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_BADFREE = 2'd2;

	typedef struct packed {
		logic        cmd;
		logic [14:0] request_size;
		logic [14:0] free_address;
	} in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [14:0] block_address;
	} out_t;

endpackage

>>> rtl/core/ffha_ram.sv
module ffha_ram import ffha_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = HEAP_BYTES_DEFAULT
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/first_fit_heap_allocator.sv
// First-fit heap allocator over an implicit block list kept in a byte RAM.
// After reset the block sweeps the whole heap, one byte per cycle, and it
// stays busy through the sweep before the first item is taken. A free item
// has its result in the cycle after it is accepted. An allocate item walks
// the block headers from offset 0 through the byte-wide read port of the
// heap RAM, reading the size bytes and the flags byte of each header; a fit
// then writes the split headers and the used flag when the block is split,
// and only the used flag when taken whole. A walk that runs out of heap
// reports no space. Each result is shown on result for one cycle with strobe
// high and must be captured then, as the receiver cannot stall the block.
module first_fit_heap_allocator import ffha_pkg::*; #(
	parameter int HEAP_BYTES = HEAP_BYTES_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  in_t  request,
	output logic strobe,
	output out_t result
);

	localparam int AW = $clog2(HEAP_BYTES);
	localparam logic [SUM_W-1:0] HEAP_LIM = SUM_W'(HEAP_BYTES - HDR_LEN);
	localparam logic [SUM_W-1:0] HEAP_TOP = SUM_W'(HEAP_BYTES);
	localparam logic [SIZE_W-1:0] INIT_SIZE = SIZE_W'(HEAP_BYTES - HDR_LEN);
	localparam logic [AW-1:0] CLR_LAST = AW'(HEAP_BYTES - 1);

	localparam logic [3:0] WI_REQ = 4'd0;
	localparam logic [3:0] WI_REQ_END = 4'd3;
	localparam logic [3:0] WI_NEW = 4'd4;
	localparam logic [3:0] WI_NEW_END = 4'd7;
	localparam logic [3:0] WI_NEW_FLAGS = 4'd8;
	localparam logic [3:0] WI_FLAGS = 4'd9;
	localparam logic [2:0] RI_FLAGS = 3'd4;

	typedef enum logic [7:0] {
		S_CLEAR = 8'b00000001,
		S_IDLE  = 8'b00000010,
		S_NEXT  = 8'b00000100,
		S_READ  = 8'b00001000,
		S_LAST  = 8'b00010000,
		S_EVAL  = 8'b00100000,
		S_FIT   = 8'b01000000,
		S_WRITE = 8'b10000000
	} state_t;

	state_t            state_q;
	logic [AW-1:0]     clr_q;
	logic [AW-1:0]     off_q;
	logic [SUM_W-1:0]  sum_q;
	logic [14:0]       req_q;
	logic [SIZE_W-1:0] stride_q;
	logic [7:0]        flags_q;
	logic [SIZE_W-1:0] size_q;
	logic              split_q;
	logic [2:0]        idx_q;
	logic [3:0]        widx_q;
	logic              rd_vld_s1;
	logic [2:0]        rd_idx_s1;
	logic              strobe_q;
	out_t              result_q;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [7:0]        ram_wdata;
	logic [AW-1:0]     ram_raddr;
	logic [7:0]        ram_rdata;

	logic [SIZE_W-1:0] req32;
	logic              fit;
	logic [SUM_W-1:0]  sum_d;
	logic [SIZE_W-1:0] diff;
	logic              accept;
	logic              free_ok;
	logic [SUM_W-1:0]  fad_m1;
	logic [SUM_W-1:0]  payload_off;

	assign req32 = SIZE_W'(req_q);
	assign fit = ((flags_q & USED_BIT) == 8'h00) && (stride_q >= req32);
	assign sum_d = SUM_W'(off_q) + SUM_W'(HDR_LEN) + SUM_W'(fit ? req32 : stride_q);
	assign diff = stride_q - req32;
	assign accept = start && (state_q == S_IDLE);
	assign free_ok = (SUM_W'(request.free_address) >= SUM_W'(HDR_LEN))
		&& (SUM_W'(request.free_address) <= HEAP_TOP);
	assign fad_m1 = SUM_W'(request.free_address) - SUM_W'(1);
	assign payload_off = SUM_W'(off_q) + SUM_W'(HDR_LEN);

	assign ram_raddr = off_q + AW'(idx_q);

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = off_q;
		ram_wdata = 8'h00;
		case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
				ram_waddr = clr_q;
				if (clr_q < AW'(4)) begin
					ram_wdata = INIT_SIZE[8*clr_q[1:0] +: 8];
				end
			end
			S_IDLE: begin
				ram_we = accept && (request.cmd == CMD_FREE) && free_ok;
				ram_waddr = fad_m1[AW-1:0];
			end
			S_WRITE: begin
				ram_we = 1'b1;
				if (widx_q inside {[WI_REQ:WI_REQ_END]}) begin
					ram_waddr = off_q + AW'(widx_q[1:0]);
					ram_wdata = req32[8*widx_q[1:0] +: 8];
				end else if (widx_q inside {[WI_NEW:WI_NEW_END]}) begin
					ram_waddr = sum_q[AW-1:0] + AW'(widx_q[1:0]);
					ram_wdata = size_q[8*widx_q[1:0] +: 8];
				end else if (widx_q == WI_NEW_FLAGS) begin
					ram_waddr = sum_q[AW-1:0] + AW'(HDR_LEN - 1);
				end else begin
					ram_waddr = off_q + AW'(HDR_LEN - 1);
					ram_wdata = flags_q | USED_BIT;
				end
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	ffha_ram #(
		.WIDTH(8),
		.DEPTH(HEAP_BYTES)
	) u_heap (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			idx_q <= '0;
			widx_q <= '0;
			rd_vld_s1 <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			rd_vld_s1 <= (state_q == S_READ);
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == CLR_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (request.cmd == CMD_FREE) begin
							strobe_q <= 1'b1;
						end else begin
							state_q <= S_NEXT;
						end
					end
				end
				S_NEXT: begin
					idx_q <= '0;
					if (sum_q > HEAP_LIM) begin
						strobe_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					idx_q <= idx_q + 3'd1;
					if (idx_q == RI_FLAGS) begin
						state_q <= S_LAST;
					end
				end
				S_LAST: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					state_q <= fit ? S_FIT : S_NEXT;
				end
				S_FIT: begin
					widx_q <= ((diff >= SIZE_W'(HDR_LEN)) && (sum_q <= HEAP_LIM))
						? WI_REQ : WI_FLAGS;
					state_q <= S_WRITE;
				end
				S_WRITE: begin
					widx_q <= widx_q + 4'd1;
					if (widx_q == WI_FLAGS) begin
						strobe_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q;
		if (rd_vld_s1) begin
			if (rd_idx_s1 == RI_FLAGS) begin
				flags_q <= ram_rdata;
			end else begin
				stride_q[8*rd_idx_s1[1:0] +: 8] <= ram_rdata;
			end
		end
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					req_q <= request.request_size;
					sum_q <= '0;
					result_q.block_address <= '0;
					if (request.cmd == CMD_FREE) begin
						result_q.status <= free_ok ? ST_DONE : ST_BADFREE;
					end
				end
			end
			S_NEXT: begin
				off_q <= sum_q[AW-1:0];
				if (sum_q > HEAP_LIM) begin
					result_q.status <= ST_NOSPACE;
					result_q.block_address <= '0;
				end
			end
			S_EVAL: begin
				sum_q <= sum_d;
			end
			S_FIT: begin
				split_q <= (diff >= SIZE_W'(HDR_LEN)) && (sum_q <= HEAP_LIM);
				size_q <= diff - SIZE_W'(HDR_LEN);
			end
			S_WRITE: begin
				if (widx_q == WI_FLAGS) begin
					result_q.status <= ST_DONE;
					result_q.block_address <= payload_off[14:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign strobe = strobe_q;
	assign result = result_q;

	a_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !busy)
		else $error("result shown while the sequencer is still working");

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || strobe))
		else $error("accepted item neither started nor finished");

	a_fail_no_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.status != ST_DONE) |-> (result.block_address == '0))
		else $error("failed item carries a block address");

	a_split_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRITE && widx_q == WI_REQ) |-> split_q)
		else $error("split header written for a block taken whole");

endmodule
